@@ rtl/sample_playback_voice_core_macros.svh @@
// Assertion helpers for the sample playback voice core.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef SAMPLE_PLAYBACK_VOICE_CORE_MACROS_SVH
`define SAMPLE_PLAYBACK_VOICE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spv_pkg.sv @@
`default_nettype none

package spv_pkg;

  // Port widths fixed by the item format.
  localparam int FUNC_W     = 2;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SMP_WORD_W = 32;

  // Register reset values.
  localparam logic [23:0] RST_BASE_STEP = 24'h01_0000;
  localparam logic [15:0] RST_GAIN      = 16'h8000;
  localparam logic [6:0]  RST_ROOT_NOTE = 7'd60;
  localparam logic [7:0]  NO_NOTE       = 8'hFF;

  // Note offset bias so that (note - root + bias) is never negative.
  localparam int NOTE_BIAS   = 132;
  // Division by 12 as a multiply by a reciprocal: q = (t * 683) >> 13, exact for t < 512.
  localparam int DIV12_MUL   = 683;
  localparam int DIV12_SHIFT = 13;
  // Octave index that corresponds to a zero octave shift.
  localparam int OCT_ZERO    = 11;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_NOTE_ON  = 2'd1,
    FUNC_NOTE_OFF = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POS  = 3'd0,
    REG_END_POS    = 3'd1,
    REG_LOOP_EN    = 3'd2,
    REG_BASE_STEP  = 3'd3,
    REG_GAIN_LEFT  = 3'd4,
    REG_GAIN_RIGHT = 3'd5,
    REG_ROOT_NOTE  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_RD0,
    ST_RD1,
    ST_INT,
    ST_SCL,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;
    logic note_on;
    logic note_off;
    logic pos;
    logic rd0;
    logic rd1;
    logic interp;
    logic scale;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic out_free;
  } sts_t;

  // 2^(k/12) in Q1.16 for one octave.
  function automatic logic [16:0] semitone_ratio(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/spv_ram.sv @@
`default_nettype none

module spv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/spv_ctrl.sv @@
`default_nettype none

module spv_ctrl
  import spv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a tick walks the sequence, every other request finishes in idle.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (func_t'(in_func) == FUNC_TICK)) begin
          state_nxt = ST_POS;
        end
      end
      ST_POS:  state_nxt = sts.go ? ST_RD0 : ST_OUT;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_INT;
      ST_INT:  state_nxt = ST_SCL;
      ST_SCL:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: request decode in idle, one datapath command per tick step.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (func_t'(in_func))
            FUNC_WRITE:    cmd.write    = 1'b1;
            FUNC_NOTE_ON:  cmd.note_on  = 1'b1;
            FUNC_NOTE_OFF: cmd.note_off = 1'b1;
            FUNC_TICK:     ;
            default:       ;
          endcase
        end
      end
      ST_POS:  cmd.pos      = 1'b1;
      ST_RD0:  cmd.rd0      = 1'b1;
      ST_RD1:  cmd.rd1      = 1'b1;
      ST_INT:  cmd.interp   = 1'b1;
      ST_SCL:  cmd.scale    = 1'b1;
      ST_OUT:  cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/spv_dp.sv @@
`default_nettype none

module spv_dp
  import spv_pkg::*;
#(
  parameter int unsigned MEM_DEPTH   = 65536,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [6:0]           in_note,
  input  logic [15:0]          in_velocity,
  input  logic [15:0]          in_sample_addr,
  input  logic signed [15:0]   in_sample_left,
  input  logic signed [15:0]   in_sample_right,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic signed [15:0]   out_left,
  output logic signed [15:0]   out_right,
  output logic                 out_playing
);

  // Only 16 address bits reach the memory.
  localparam int MD  = (MEM_DEPTH < 65536) ? int'(MEM_DEPTH) : 65536;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
  // Sample value width, interpolation and scaling product widths.
  localparam int VW  = SAMPLE_BITS + 1;
  localparam int DPW = VW + FRAC_BITS + 2;
  localparam int PW  = VW + 33;
  localparam int RW  = PW - 30;
  // Position compare width: holds a window address in position units and a sum.
  localparam int EW  = ((FRAC_BITS > 16) ? (16 + FRAC_BITS) : 32) + 1;
  // Right shift of (p << 2): 2 - (oct + FRAC_BITS - 32) with oct = q - OCT_ZERO.
  localparam int SHB = 2 + OCT_ZERO + 32 - FRAC_BITS;
  localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  logic [15:0] start_r;
  logic [15:0] end_r;
  logic        loop_r;
  logic [23:0] base_r;
  logic [15:0] gain_r [2];
  logic [6:0]  root_r;

  // Voice state.
  logic [31:0] pos_r;
  logic [31:0] pos_nxt;
  logic        playing_r;
  logic        playing_nxt;
  logic        has_smp_r;
  logic [7:0]  cur_note_r;
  logic [15:0] vel_r;

  // Tick working registers.
  logic                  silent_r;
  logic [15:0]           ip_r;
  logic                  v0_r;
  logic                  v1_r;
  logic [4:0]            oct_r;
  logic [3:0]            semi_r;
  logic [31:0]           vg_r [2];
  logic [40:0]           p_r;
  logic [31:0]           step_r;
  logic signed [VW-1:0]  a_r [2];
  logic signed [VW-1:0]  iv_r [2];
  logic signed [PW-1:0]  sc_r [2];
  logic                  out_valid_r;
  logic signed [15:0]    out_l_r;
  logic signed [15:0]    out_rt_r;
  logic                  out_play_r;

  // Combinational signals.
  logic                  addr_ok;
  logic                  ram_we;
  logic [15:0]           rd_addr;
  logic [SMP_WORD_W-1:0] ram_rdata;
  logic signed [VW-1:0]  ext [2];
  logic                  active;
  logic [EW-1:0]         spos_e;
  logic [EW-1:0]         epos_e;
  logic [31:0]           spos;
  logic [31:0]           raised;
  logic                  at_end;
  logic [31:0]           pos1;
  logic                  go;
  logic [EW-1:0]         ip_w;
  logic [8:0]            note_t;
  logic [18:0]           tq;
  logic [4:0]            oct;
  logic [8:0]            q12;
  logic [8:0]            rem;
  logic [5:0]            shamt;
  logic [42:0]           psh;
  logic [31:0]           step_nxt;
  logic [EW-1:0]         sum;
  logic [31:0]           npos;
  logic                  past_end;
  logic signed [VW:0]    diff [2];
  logic signed [VW-1:0]  b_val [2];
  logic signed [DPW-1:0] dprod [2];
  logic signed [DPW-1:0] dsh [2];
  logic signed [VW-1:0]  iv_nxt [2];
  logic signed [PW-1:0]  sc_nxt [2];
  logic signed [PW-1:0]  rsh [2];
  logic signed [RW-1:0]  rv [2];
  logic signed [RW-1:0]  sat [2];
  logic signed [FRAC_BITS:0] fr;

  // Sample memory: one stereo word per address, right channel in the upper half.
  assign addr_ok = ({1'b0, in_sample_addr} < 17'(MD));
  assign ram_we  = cmd.write && addr_ok;
  assign rd_addr = cmd.rd1 ? (ip_r + 16'd1) : ip_r;

  spv_ram #(
    .WIDTH (SMP_WORD_W),
    .DEPTH (MD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_sample_addr[AW-1:0]),
    .wdata ({in_sample_right, in_sample_left}),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Stored words are taken as SAMPLE_BITS-bit two's complement values; above 16 bits the half is zero-extended.
  for (genvar g = 0; g < 2; g++) begin : g_ext
    logic [15:0] raw;
    assign raw = ram_rdata[16*g +: 16];
    if (SAMPLE_BITS <= 16) begin : g_sx
      assign ext[g] = VW'($signed(raw[SAMPLE_BITS-1:0]));
    end else begin : g_zx
      assign ext[g] = $signed({{(VW-16){1'b0}}, raw});
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      end_r     <= '0;
      loop_r    <= 1'b0;
      base_r    <= RST_BASE_STEP;
      gain_r[0] <= RST_GAIN;
      gain_r[1] <= RST_GAIN;
      root_r    <= RST_ROOT_NOTE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_POS:  start_r   <= cfg_data[15:0];
        REG_END_POS:    end_r     <= cfg_data[15:0];
        REG_LOOP_EN:    loop_r    <= cfg_data[0];
        REG_BASE_STEP:  base_r    <= cfg_data[23:0];
        REG_GAIN_LEFT:  gain_r[0] <= cfg_data[15:0];
        REG_GAIN_RIGHT: gain_r[1] <= cfg_data[15:0];
        REG_ROOT_NOTE:  root_r    <= cfg_data[6:0];
        default:        ;
      endcase
    end
  end

  // Window check at the start of a tick: raise to the window start, then handle the end.
  always_comb begin
    active = playing_r && has_smp_r && (start_r < end_r);
    spos_e = EW'(start_r) << FRAC_BITS;
    epos_e = EW'(end_r) << FRAC_BITS;
    spos   = (spos_e > EW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : spos_e[31:0];
    raised = (pos_r < spos) ? spos : pos_r;
    at_end = ((EW'(raised) >> FRAC_BITS) >= EW'(end_r));
    pos1   = (at_end && loop_r) ? spos : raised;
    go     = active && (!at_end || loop_r);
    ip_w   = EW'(pos1) >> FRAC_BITS;
  end

  // Pitch: split (note - root + bias) into octave and semitone.
  always_comb begin
    note_t = {2'b00, cur_note_r[6:0]} + 9'(NOTE_BIAS) - {2'b00, root_r};
    tq     = 19'(note_t) * 19'(DIV12_MUL);
    oct    = tq[DIV12_SHIFT +: 5];
    q12    = (9'(oct) << 3) + (9'(oct) << 2);
    rem    = note_t - q12;
  end

  // Step: scale the ratio product by the octave, then saturate to 32 bits.
  always_comb begin
    shamt    = 6'(SHB) - {1'b0, oct_r};
    psh      = {p_r, 2'b00} >> shamt;
    step_nxt = (|psh[42:32]) ? 32'hFFFF_FFFF : psh[31:0];
  end

  // Position advance and end handling after the samples are read.
  always_comb begin
    sum      = EW'(pos_r) + EW'(step_r);
    npos     = (sum > EW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sum[31:0];
    past_end = (EW'(npos) >= epos_e);
  end

  // Interpolation a + (b - a) * f, scaling and saturation, per channel.
  always_comb begin
    fr = $signed({1'b0, pos_r[FRAC_BITS-1:0]});
    for (int ch = 0; ch < 2; ch++) begin
      b_val[ch]  = v1_r ? ext[ch] : '0;
      diff[ch]   = b_val[ch] - a_r[ch];
      dprod[ch]  = diff[ch] * fr;
      dsh[ch]    = dprod[ch] >>> FRAC_BITS;
      iv_nxt[ch] = a_r[ch] + $signed(dsh[ch][VW-1:0]);
      sc_nxt[ch] = iv_r[ch] * $signed({1'b0, vg_r[ch]});
      rsh[ch]    = sc_r[ch] >>> 30;
      rv[ch]     = $signed(rsh[ch][RW-1:0]);
      if (rv[ch] > SAT_HI) begin
        sat[ch] = SAT_HI;
      end else if (rv[ch] < SAT_LO) begin
        sat[ch] = SAT_LO;
      end else begin
        sat[ch] = rv[ch];
      end
    end
  end

  // Next voice position and play flag.
  always_comb begin
    pos_nxt     = pos_r;
    playing_nxt = playing_r;
    if (ram_we) begin
      pos_nxt     = '0;
      playing_nxt = 1'b0;
    end else if (cmd.note_on) begin
      pos_nxt     = '0;
      playing_nxt = 1'b1;
    end else if (cmd.note_off) begin
      if (cur_note_r == {1'b0, in_note}) begin
        playing_nxt = 1'b0;
      end
    end else if (cmd.pos && active) begin
      pos_nxt = pos1;
      if (at_end && !loop_r) begin
        playing_nxt = 1'b0;
      end
    end else if (cmd.interp) begin
      pos_nxt = (past_end && loop_r) ? spos : npos;
      if (past_end && !loop_r) begin
        playing_nxt = 1'b0;
      end
    end
  end

  // Voice state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      playing_r  <= 1'b0;
      has_smp_r  <= 1'b0;
      cur_note_r <= NO_NOTE;
      vel_r      <= '0;
    end else begin
      pos_r     <= pos_nxt;
      playing_r <= playing_nxt;
      if (ram_we) begin
        has_smp_r <= 1'b1;
      end
      if (cmd.note_on) begin
        cur_note_r <= {1'b0, in_note};
        vel_r      <= in_velocity;
      end
    end
  end

  // Tick pipeline registers, each loaded in its own step.
  always_ff @(posedge clk) begin
    if (cmd.pos) begin
      silent_r <= !go;
      ip_r     <= ip_w[15:0];
      v0_r     <= ({1'b0, ip_w[15:0]} < 17'(MD));
      v1_r     <= (({1'b0, ip_w[15:0]} + 17'd1) < 17'(MD));
      oct_r    <= oct;
      semi_r   <= rem[3:0];
      for (int ch = 0; ch < 2; ch++) begin
        vg_r[ch] <= vel_r * gain_r[ch];
      end
    end
    if (cmd.rd0) begin
      p_r <= 41'(base_r) * 41'(semitone_ratio(semi_r));
    end
    if (cmd.rd1) begin
      step_r <= step_nxt;
      for (int ch = 0; ch < 2; ch++) begin
        a_r[ch] <= v0_r ? ext[ch] : '0;
      end
    end
    if (cmd.interp) begin
      for (int ch = 0; ch < 2; ch++) begin
        iv_r[ch] <= iv_nxt[ch];
      end
    end
    if (cmd.scale) begin
      for (int ch = 0; ch < 2; ch++) begin
        sc_r[ch] <= sc_nxt[ch];
      end
    end
  end

  // Output register: holds one result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_l_r    <= silent_r ? 16'sd0 : 16'(sat[0]);
      out_rt_r   <= silent_r ? 16'sd0 : 16'(sat[1]);
      out_play_r <= playing_r;
    end
  end

  assign sts.go       = go;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_left    = out_l_r;
  assign out_right   = out_rt_r;
  assign out_playing = out_play_r;

endmodule

`default_nettype wire

@@ rtl/sample_playback_voice_core.sv @@
// Single-voice sample player with linear interpolation.
// Input requests use in_valid/in_ready. in_func selects: write a stereo word into
// sample memory (stops the voice), note on (restarts from the window start), note
// off (stops the voice when the note matches) or tick (produces one stereo result).
// Only a tick produces a result, on out_valid/out_ready with out_left, out_right
// and out_playing. Registers are written through cfg_we/cfg_index/cfg_data.
// Write, note-on and note-off requests complete in the cycle they are accepted.
// A tick that plays steps through position, two reads, interpolation, scaling
// and output, and the next request is taken once it is back in idle; a silent
// tick goes from the position step straight to output. The two samples around
// the play position come from the single read port of the sample memory in
// turn, and the step and the gain products run through registered multiply stages.
// The output register holds one result: the next request is accepted while it
// waits, and a following tick holds in its last step until the receiver takes it.
// Reset (rst_n low, synchronous) stops the voice, clears the play position, marks
// no sample and no note, and sets the registers to their defaults. The sample
// memory is not cleared; it has to be written before it is played.
`default_nettype none

`include "sample_playback_voice_core_macros.svh"

module sample_playback_voice_core
  import spv_pkg::*;
#(
  parameter int unsigned MEM_DEPTH   = 65536,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [6:0]           in_note,
  input  logic [15:0]          in_velocity,
  input  logic [15:0]          in_sample_addr,
  input  logic signed [15:0]   in_sample_left,
  input  logic signed [15:0]   in_sample_right,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_left,
  output logic signed [15:0]   out_right,
  output logic                 out_playing,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t spv_cmd;
  sts_t spv_sts;

  // Sequencer for the request types and the tick steps.
  spv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (spv_sts),
    .cmd      (spv_cmd)
  );

  // Sample memory, voice state and arithmetic.
  spv_dp #(
    .MEM_DEPTH   (MEM_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (spv_cmd),
    .sts             (spv_sts),
    .in_note         (in_note),
    .in_velocity     (in_velocity),
    .in_sample_addr  (in_sample_addr),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_playing     (out_playing)
  );

  // A tick keeps the voice busy after it is accepted.
  `SPV_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_func == FUNC_TICK, !in_ready, "tick request did not occupy the voice")

  // Any other request completes in the cycle it is accepted.
  `SPV_ASSERT_NEXT(a_cmd_one_cycle, in_valid && in_ready && in_func != FUNC_TICK, in_ready, "non-tick request kept the voice busy")

  // A loaded result is offered to the receiver in the next cycle.
  `SPV_ASSERT_NEXT(a_out_load, spv_cmd.out_load, out_valid, "loaded result was not presented")

  // Requests are only decoded while the voice is ready.
  `SPV_ASSERT_NOW(a_decode_idle, spv_cmd.write || spv_cmd.note_on || spv_cmd.note_off, in_ready, "request decoded while busy")

endmodule

`default_nettype wire
